// ===== rtl/core/vmfetu_pkg.sv =====
// shared types and constants of the look-at view matrix unit
package vmfetu_pkg;

    localparam int AXIS_FRAC_DEF = 15;
    localparam int POS_W         = 32;
    localparam int DIFF_W        = POS_W + 1;
    localparam int AXIS_OUT_W    = 16;

    // matrix row codes
    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_FRONT = 2'd2;

    // one camera as handed from front to back
    typedef struct packed {
        logic [2:0][POS_W-1:0]  eye;
        logic [2:0][POS_W-1:0]  hint;
        logic [2:0][DIFF_W-1:0] fr;
        logic                   fr_zero;
    } job_t;

endpackage

// ===== rtl/core/view_matrix_from_eye_target_up_unit.sv =====
// top level of the look-at view matrix unit
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------------
//  camera in | start, busy            | eye_x/y/z, aim_x/y/z, hint_x/y/z
//  rows out  | result_strobe          | row_index, axis_x/y/z, shift_term, degenerate,
//            |                        | last_row
//
//  A camera goes through three normalizations with their scaling shifts, two crosses and
//  three row dots; the bit-serial square root and divider and the one shared 33x33
//  multiplier set its run time. A zero front gives its three rows back to back once the
//  camera leaves the queue; a front parallel to the hint does so after the front
//  normalization and the first cross.
//  A two-entry queue takes new cameras while the back end works; busy is high when full.
//  Reset is asynchronous, active low. Rows leave on the strobe and cannot be held off.
module view_matrix_from_eye_target_up_unit #(
    parameter int AXIS_FRAC_BITS = vmfetu_pkg::AXIS_FRAC_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [vmfetu_pkg::POS_W-1:0]      eye_x,
    input  logic [vmfetu_pkg::POS_W-1:0]      eye_y,
    input  logic [vmfetu_pkg::POS_W-1:0]      eye_z,
    input  logic [vmfetu_pkg::POS_W-1:0]      aim_x,
    input  logic [vmfetu_pkg::POS_W-1:0]      aim_y,
    input  logic [vmfetu_pkg::POS_W-1:0]      aim_z,
    input  logic [vmfetu_pkg::POS_W-1:0]      hint_x,
    input  logic [vmfetu_pkg::POS_W-1:0]      hint_y,
    input  logic [vmfetu_pkg::POS_W-1:0]      hint_z,
    output logic                              result_strobe,
    output logic [1:0]                        row_index,
    output logic [vmfetu_pkg::AXIS_OUT_W-1:0] axis_x,
    output logic [vmfetu_pkg::AXIS_OUT_W-1:0] axis_y,
    output logic [vmfetu_pkg::AXIS_OUT_W-1:0] axis_z,
    output logic [vmfetu_pkg::POS_W-1:0]      shift_term,
    output logic                              degenerate,
    output logic                              last_row
);
    import vmfetu_pkg::*;

    job_t job;
    logic job_valid;
    logic job_pop;

    // accept and queue
    vmfetu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .eye_x    (eye_x),
        .eye_y    (eye_y),
        .eye_z    (eye_z),
        .aim_x    (aim_x),
        .aim_y    (aim_y),
        .aim_z    (aim_z),
        .hint_x   (hint_x),
        .hint_y   (hint_y),
        .hint_z   (hint_z),
        .job      (job),
        .job_valid(job_valid),
        .job_pop  (job_pop)
    );

    // compute and emit rows
    vmfetu_back #(.AXIS_FRAC_BITS(AXIS_FRAC_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (job),
        .job_valid    (job_valid),
        .job_pop      (job_pop),
        .result_strobe(result_strobe),
        .row_index    (row_index),
        .axis_x       (axis_x),
        .axis_y       (axis_y),
        .axis_z       (axis_z),
        .shift_term   (shift_term),
        .degenerate   (degenerate),
        .last_row     (last_row)
    );

endmodule

// ===== rtl/core/vmfetu_front.sv =====
// input side: takes cameras, forms front vector, queues them for the back end
module vmfetu_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [vmfetu_pkg::POS_W-1:0] eye_x,
    input  logic [vmfetu_pkg::POS_W-1:0] eye_y,
    input  logic [vmfetu_pkg::POS_W-1:0] eye_z,
    input  logic [vmfetu_pkg::POS_W-1:0] aim_x,
    input  logic [vmfetu_pkg::POS_W-1:0] aim_y,
    input  logic [vmfetu_pkg::POS_W-1:0] aim_z,
    input  logic [vmfetu_pkg::POS_W-1:0] hint_x,
    input  logic [vmfetu_pkg::POS_W-1:0] hint_y,
    input  logic [vmfetu_pkg::POS_W-1:0] hint_z,
    output vmfetu_pkg::job_t            job,
    output logic                        job_valid,
    input  logic                        job_pop
);
    import vmfetu_pkg::*;

    job_t        q_mem [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;
    job_t        new_job;

    // classify: front difference and zero check
    always_comb
    begin
        new_job.eye  = {eye_z, eye_y, eye_x};
        new_job.hint = {hint_z, hint_y, hint_x};
        new_job.fr[0] = DIFF_W'($signed({aim_x[POS_W-1], aim_x}) -
                                $signed({eye_x[POS_W-1], eye_x}));
        new_job.fr[1] = DIFF_W'($signed({aim_y[POS_W-1], aim_y}) -
                                $signed({eye_y[POS_W-1], eye_y}));
        new_job.fr[2] = DIFF_W'($signed({aim_z[POS_W-1], aim_z}) -
                                $signed({eye_z[POS_W-1], eye_z}));
        new_job.fr_zero = (new_job.fr[0] == '0) && (new_job.fr[1] == '0) &&
                          (new_job.fr[2] == '0);
    end

    // queue control
    assign busy      = (count_reg == 2'd2);
    assign push      = start && !busy;
    assign pop       = job_pop && (count_reg != 2'd0);
    assign job_valid = (count_reg != 2'd0);
    assign job       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_job;
        end
    end

endmodule

// ===== rtl/core/vmfetu_sqrt.sv =====
// bit-serial integer square root, two radicand bits per cycle
module vmfetu_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [61:0] x,
    output logic [30:0] root,
    output logic        done
);
    import vmfetu_pkg::*;

    logic [61:0] x_reg;
    logic [33:0] rem_reg;
    logic [30:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [33:0] rem_sh;
    logic [33:0] trial;

    assign rem_sh = {rem_reg[31:0], x_reg[61:60]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign root   = root_reg;
    assign done   = done_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd30;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one root bit per step
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            x_reg    <= x;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= {x_reg[59:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[29:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[29:0], 1'b0};
            end
        end
    end

endmodule

// ===== rtl/core/vmfetu_div.sv =====
// restoring divider for unit components, one quotient bit per cycle
module vmfetu_div #(
    parameter int AXIS_FRAC_BITS = vmfetu_pkg::AXIS_FRAC_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic [AXIS_FRAC_BITS+30:0] num,
    input  logic [30:0]               den,
    output logic [AXIS_FRAC_BITS:0]   quo,
    output logic                      done
);
    import vmfetu_pkg::*;

    localparam int F     = AXIS_FRAC_BITS;
    localparam int Q_W   = F + 1;
    localparam int CNT_W = $clog2(F + 1);

    logic [31:0]      rem_reg;
    logic [Q_W-1:0]   low_reg;
    logic [Q_W-1:0]   q_reg;
    logic [30:0]      den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [31:0]      rem_sh;
    logic             fits;

    assign rem_sh = {rem_reg[30:0], low_reg[Q_W-1]};
    assign fits   = (rem_sh >= {1'b0, den_reg});
    assign quo    = q_reg;
    assign done   = done_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(F);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits; upper numerator part is already below the divisor
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= {2'b00, num[F+30:F+1]};
            low_reg <= num[F:0];
            q_reg   <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            low_reg <= {low_reg[Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[Q_W-2:0], fits};
            rem_reg <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        end
    end

endmodule

// ===== rtl/core/vmfetu_back.sv =====
// back end: sequencer with shared multiplier, scaler, root and divider
module vmfetu_back #(
    parameter int AXIS_FRAC_BITS = vmfetu_pkg::AXIS_FRAC_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vmfetu_pkg::job_t                  job,
    input  logic                              job_valid,
    output logic                              job_pop,
    output logic                              result_strobe,
    output logic [1:0]                        row_index,
    output logic [vmfetu_pkg::AXIS_OUT_W-1:0] axis_x,
    output logic [vmfetu_pkg::AXIS_OUT_W-1:0] axis_y,
    output logic [vmfetu_pkg::AXIS_OUT_W-1:0] axis_z,
    output logic [vmfetu_pkg::POS_W-1:0]      shift_term,
    output logic                              degenerate,
    output logic                              last_row
);
    import vmfetu_pkg::*;

    localparam int F     = AXIS_FRAC_BITS;
    localparam int UW    = F + 2;
    localparam int NUM_W = F + 31;
    localparam int MAG_W = 62;
    localparam int MUL_W = 33;
    localparam int ACC_W = 66;
    localparam logic signed [ACC_W-1:0] SAT_HI =
        $signed({{(ACC_W-32){1'b0}}, 32'h7FFF_FFFF});
    localparam logic signed [ACC_W-1:0] SAT_LO =
        $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000});
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (F - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCALE, S_MUL, S_ACC, S_ROOT, S_ROOT_WAIT, S_DIV, S_DIV_WAIT, S_OUT
    } state_t;
    typedef enum logic [1:0] {PH_FRONT, PH_NF, PH_CR, PH_CU} phase_t;
    typedef enum logic [1:0] {OP_SQ, OP_CROSS, OP_DOT} op_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    op_t    op_reg, op_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] row_reg, row_next;
    logic       degen_reg, degen_next;
    logic       strobe_reg, strobe_next;
    logic [1:0] row_out_reg, row_out_next;
    logic [AXIS_OUT_W-1:0] ax_reg [3];
    logic [AXIS_OUT_W-1:0] ax_next [3];
    logic [POS_W-1:0] sh_reg, sh_next;
    logic       deg_out_reg, deg_out_next;
    logic       last_reg, last_next;

    logic signed [POS_W-1:0] eye_reg [3];
    logic signed [POS_W-1:0] eye_next [3];
    logic signed [POS_W-1:0] hint_reg [3];
    logic signed [POS_W-1:0] hint_next [3];
    logic                    vs_reg [3];
    logic                    vs_next [3];
    logic [MAG_W-1:0]        vm_reg [3];
    logic [MAG_W-1:0]        vm_next [3];
    logic signed [30:0]      fs_reg [3];
    logic signed [30:0]      fs_next [3];
    logic signed [UW-1:0]    fn_reg [3];
    logic signed [UW-1:0]    fn_next [3];
    logic signed [UW-1:0]    rn_reg [3];
    logic signed [UW-1:0]    rn_next [3];
    logic signed [UW-1:0]    un_reg [3];
    logic signed [UW-1:0]    un_next [3];
    logic signed [UW-1:0]    row_vec [3];
    logic signed [ACC_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [30:0]             len_reg, len_next;

    logic signed [MUL_W-1:0] opa;
    logic signed [MUL_W-1:0] opb;
    logic [1:0]              kc;
    logic [1:0]              ia;
    logic [1:0]              ib;
    logic [1:0]              ci;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] acc_mag;
    logic signed [ACC_W-1:0] sh_t;
    logic signed [ACC_W-1:0] sh_n;
    logic                    all_zero;
    logic                    hi38;
    logic                    hi30;
    logic                    hi29;
    logic                    hi21;
    logic                    sqrt_go;
    logic                    sqrt_done;
    logic [30:0]             sqrt_root;
    logic                    div_go;
    logic                    div_done;
    logic [F:0]              div_q;
    logic [NUM_W-1:0]        div_num;
    logic signed [UW-1:0]    q_signed;

    function automatic logic [1:0] rot1(input logic [1:0] k);
        case (k)
            2'd0:    return 2'd1;
            2'd1:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] rot2(input logic [1:0] k);
        case (k)
            2'd0:    return 2'd2;
            2'd1:    return 2'd0;
            default: return 2'd1;
        endcase
    endfunction

    function automatic logic [AXIS_OUT_W-1:0] sat_axis(input logic signed [UW-1:0] v);
        logic signed [MUL_W-1:0] w;
        w = {{(MUL_W-UW){v[UW-1]}}, v};
        if (w > 33'sd32767)
            return 16'h7FFF;
        else if (w < -33'sd32768)
            return 16'h8000;
        else
            return w[AXIS_OUT_W-1:0];
    endfunction

    vmfetu_sqrt u_sqrt (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (sqrt_go),
        .x    (acc_reg[61:0]),
        .root (sqrt_root),
        .done (sqrt_done)
    );

    vmfetu_div #(.AXIS_FRAC_BITS(F)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (div_go),
        .num  (div_num),
        .den  (len_reg),
        .quo  (div_q),
        .done (div_done)
    );

    // range tests over the scaling workspace
    always_comb
    begin
        all_zero = (vm_reg[0] == '0) && (vm_reg[1] == '0) && (vm_reg[2] == '0);
        hi38 = |(vm_reg[0][MAG_W-1:38] | vm_reg[1][MAG_W-1:38] | vm_reg[2][MAG_W-1:38]);
        hi30 = |(vm_reg[0][MAG_W-1:30] | vm_reg[1][MAG_W-1:30] | vm_reg[2][MAG_W-1:30]);
        hi29 = |(vm_reg[0][MAG_W-1:29] | vm_reg[1][MAG_W-1:29] | vm_reg[2][MAG_W-1:29]);
        hi21 = |(vm_reg[0][MAG_W-1:21] | vm_reg[1][MAG_W-1:21] | vm_reg[2][MAG_W-1:21]);
    end

    // matrix rows
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            row_vec[i] = rn_reg[i];
            case (row_reg)
                ROW_RIGHT: row_vec[i] = rn_reg[i];
                ROW_UP:    row_vec[i] = un_reg[i];
                default:   row_vec[i] = -fn_reg[i];
            endcase
        end
    end

    // multiplier operand select
    always_comb
    begin
        kc = cnt_reg[2:1];
        ci = cnt_reg[1:0];
        ia = cnt_reg[0] ? rot2(kc) : rot1(kc);
        ib = cnt_reg[0] ? rot1(kc) : rot2(kc);
        opa = '0;
        opb = '0;
        case (op_reg)
            OP_SQ:
            begin
                opa = $signed({3'b000, vm_reg[ci][29:0]});
                opb = opa;
            end
            OP_CROSS:
            begin
                if (phase_reg == PH_CR)
                begin
                    opa = {{(MUL_W-31){fs_reg[ia][30]}}, fs_reg[ia]};
                    opb = {hint_reg[ib][POS_W-1], hint_reg[ib]};
                end
                else
                begin
                    opa = {{(MUL_W-UW){rn_reg[ia][UW-1]}}, rn_reg[ia]};
                    opb = {{(MUL_W-UW){fn_reg[ib][UW-1]}}, fn_reg[ib]};
                end
            end
            default:
            begin
                opa = {{(MUL_W-UW){row_vec[ci][UW-1]}}, row_vec[ci]};
                opb = {eye_reg[ci][POS_W-1], eye_reg[ci]};
            end
        endcase
    end

    // arithmetic helpers
    always_comb
    begin
        acc_sum  = (op_reg == OP_CROSS && cnt_reg[0]) ? acc_reg - prod_reg
                                                      : acc_reg + prod_reg;
        acc_mag  = acc_sum[ACC_W-1] ? -acc_sum : acc_sum;
        sh_t     = (acc_reg + HALF) >>> F;
        sh_n     = -sh_t;
        div_num  = {1'b0, vm_reg[ci][29:0], {F{1'b0}}} + {{(NUM_W-30){1'b0}}, len_reg[30:1]};
        q_signed = vs_reg[ci] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        sqrt_go  = (state_reg == S_ROOT);
        div_go   = (state_reg == S_DIV);
        job_pop  = (state_reg == S_IDLE) && job_valid;
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        op_next      = op_reg;
        cnt_next     = cnt_reg;
        row_next     = row_reg;
        degen_next   = degen_reg;
        strobe_next  = 1'b0;
        row_out_next = row_out_reg;
        sh_next      = sh_reg;
        deg_out_next = deg_out_reg;
        last_next    = last_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        len_next     = len_reg;
        for (int i = 0; i < 3; i++)
        begin
            ax_next[i]   = ax_reg[i];
            eye_next[i]  = eye_reg[i];
            hint_next[i] = hint_reg[i];
            vs_next[i]   = vs_reg[i];
            vm_next[i]   = vm_reg[i];
            fs_next[i]   = fs_reg[i];
            fn_next[i]   = fn_reg[i];
            rn_next[i]   = rn_reg[i];
            un_next[i]   = un_reg[i];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        eye_next[i]  = $signed(job.eye[i]);
                        hint_next[i] = $signed(job.hint[i]);
                        vs_next[i]   = job.fr[i][DIFF_W-1];
                        vm_next[i]   = MAG_W'(DIFF_W'(job.fr[i][DIFF_W-1] ? -job.fr[i]
                                                                         : job.fr[i]));
                    end
                    row_next = ROW_RIGHT;
                    if (job.fr_zero)
                    begin
                        degen_next = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        degen_next = 1'b0;
                        phase_next = PH_FRONT;
                        state_next = S_SCALE;
                    end
                end
            end

            // bring largest magnitude into [2^29, 2^30); an all-zero vector gives a degenerate matrix or a zero up row
            S_SCALE:
            begin
                if (all_zero)
                begin
                    row_next = ROW_RIGHT;
                    if (phase_reg == PH_CU)
                    begin
                        for (int i = 0; i < 3; i++)
                            un_next[i] = '0;
                        op_next    = OP_DOT;
                        cnt_next   = '0;
                        acc_next   = '0;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        degen_next = 1'b1;
                        state_next = S_OUT;
                    end
                end
                else if (hi38)
                begin
                    for (int i = 0; i < 3; i++)
                        vm_next[i] = vm_reg[i] >> 8;
                end
                else if (hi30)
                begin
                    for (int i = 0; i < 3; i++)
                        vm_next[i] = vm_reg[i] >> 1;
                end
                else if (!hi21)
                begin
                    for (int i = 0; i < 3; i++)
                        vm_next[i] = vm_reg[i] << 8;
                end
                else if (!hi29)
                begin
                    for (int i = 0; i < 3; i++)
                        vm_next[i] = vm_reg[i] << 1;
                end
                else
                begin
                    if (phase_reg == PH_FRONT)
                    begin
                        for (int i = 0; i < 3; i++)
                            fs_next[i] = vs_reg[i] ? -$signed({1'b0, vm_reg[i][29:0]})
                                                   : $signed({1'b0, vm_reg[i][29:0]});
                        phase_next = PH_NF;
                    end
                    op_next    = OP_SQ;
                    cnt_next   = '0;
                    acc_next   = '0;
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                prod_next  = opa * opb;
                state_next = S_ACC;
            end

            S_ACC:
            begin
                state_next = S_MUL;
                cnt_next   = cnt_reg + 3'd1;
                acc_next   = acc_sum;
                case (op_reg)
                    OP_SQ:
                    begin
                        if (cnt_reg == 3'd2)
                            state_next = S_ROOT;
                    end
                    OP_CROSS:
                    begin
                        if (cnt_reg[0])
                        begin
                            vs_next[kc] = acc_sum[ACC_W-1];
                            vm_next[kc] = acc_mag[MAG_W-1:0];
                            acc_next    = '0;
                            if (cnt_reg == 3'd5)
                                state_next = S_SCALE;
                        end
                    end
                    default:
                    begin
                        if (cnt_reg == 3'd2)
                            state_next = S_OUT;
                    end
                endcase
            end

            S_ROOT:
            begin
                state_next = S_ROOT_WAIT;
            end

            S_ROOT_WAIT:
            begin
                if (sqrt_done)
                begin
                    len_next   = sqrt_root;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                state_next = S_DIV_WAIT;
            end

            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    case (phase_reg)
                        PH_NF:   fn_next[ci] = q_signed;
                        PH_CR:   rn_next[ci] = q_signed;
                        default: un_next[ci] = q_signed;
                    endcase
                    if (cnt_reg == 3'd2)
                    begin
                        cnt_next   = '0;
                        acc_next   = '0;
                        state_next = S_MUL;
                        case (phase_reg)
                            PH_NF:
                            begin
                                phase_next = PH_CR;
                                op_next    = OP_CROSS;
                            end
                            PH_CR:
                            begin
                                phase_next = PH_CU;
                                op_next    = OP_CROSS;
                            end
                            default:
                            begin
                                op_next  = OP_DOT;
                                row_next = ROW_RIGHT;
                            end
                        endcase
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 3'd1;
                        state_next = S_DIV;
                    end
                end
            end

            // drive one row onto the result ports
            S_OUT:
            begin
                strobe_next  = 1'b1;
                row_out_next = row_reg;
                deg_out_next = degen_reg;
                last_next    = (row_reg == ROW_FRONT);
                for (int i = 0; i < 3; i++)
                    ax_next[i] = degen_reg ? '0 : sat_axis(row_vec[i]);
                if (degen_reg)
                    sh_next = '0;
                else if (sh_n > SAT_HI)
                    sh_next = SAT_HI[POS_W-1:0];
                else if (sh_n < SAT_LO)
                    sh_next = SAT_LO[POS_W-1:0];
                else
                    sh_next = sh_n[POS_W-1:0];
                if (row_reg == ROW_FRONT)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    row_next = row_reg + 2'd1;
                    if (!degen_reg)
                    begin
                        op_next    = OP_DOT;
                        cnt_next   = '0;
                        acc_next   = '0;
                        state_next = S_MUL;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_FRONT;
            op_reg      <= OP_SQ;
            cnt_reg     <= '0;
            row_reg     <= '0;
            degen_reg   <= 1'b0;
            strobe_reg  <= 1'b0;
            row_out_reg <= '0;
            sh_reg      <= '0;
            deg_out_reg <= 1'b0;
            last_reg    <= 1'b0;
            for (int i = 0; i < 3; i++)
                ax_reg[i] <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            op_reg      <= op_next;
            cnt_reg     <= cnt_next;
            row_reg     <= row_next;
            degen_reg   <= degen_next;
            strobe_reg  <= strobe_next;
            row_out_reg <= row_out_next;
            sh_reg      <= sh_next;
            deg_out_reg <= deg_out_next;
            last_reg    <= last_next;
            for (int i = 0; i < 3; i++)
                ax_reg[i] <= ax_next[i];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        len_reg  <= len_next;
        for (int i = 0; i < 3; i++)
        begin
            eye_reg[i]  <= eye_next[i];
            hint_reg[i] <= hint_next[i];
            vs_reg[i]   <= vs_next[i];
            vm_reg[i]   <= vm_next[i];
            fs_reg[i]   <= fs_next[i];
            fn_reg[i]   <= fn_next[i];
            rn_reg[i]   <= rn_next[i];
            un_reg[i]   <= un_next[i];
        end
    end

    assign result_strobe = strobe_reg;
    assign row_index     = row_out_reg;
    assign axis_x        = ax_reg[0];
    assign axis_y        = ax_reg[1];
    assign axis_z        = ax_reg[2];
    assign shift_term    = sh_reg;
    assign degenerate    = deg_out_reg;
    assign last_row      = last_reg;

endmodule

// ===== rtl/core/vmfetu_checker.sv =====
// port-level checks for the look-at view matrix unit, bound to the top level
module vmfetu_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              result_strobe,
    input logic [1:0]                        row_index,
    input logic [vmfetu_pkg::AXIS_OUT_W-1:0] axis_x,
    input logic [vmfetu_pkg::AXIS_OUT_W-1:0] axis_y,
    input logic [vmfetu_pkg::AXIS_OUT_W-1:0] axis_z,
    input logic [vmfetu_pkg::POS_W-1:0]      shift_term,
    input logic                              degenerate,
    input logic                              last_row
);
    import vmfetu_pkg::*;

    // a degenerate row carries no geometry
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && degenerate |->
            axis_x == '0 && axis_y == '0 && axis_z == '0 && shift_term == '0)
        else $error("degenerate row with nonzero payload");

    // last flag marks exactly the front row
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (last_row == (row_index == ROW_FRONT)))
        else $error("last_row does not match row_index");

    // a new matrix never starts right after an unfinished one
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last_row |=> !(result_strobe && row_index == ROW_RIGHT))
        else $error("matrix rows out of order");

    // queue only fills on an accepted item
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted item");

endmodule

bind view_matrix_from_eye_target_up_unit vmfetu_checker u_vmfetu_checker (.*);
